/* rtl/pdfte_pkg.sv */
// Package with byte codes and helpers for the PDF content text extractor.
`timescale 1ns / 1ps

package pdfte_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CharW = 7;
  localparam int unsigned HistDepth = 4;

  localparam logic [ByteW-1:0] ChB      = 8'h42;  // 'B'
  localparam logic [ByteW-1:0] ChE      = 8'h45;  // 'E'
  localparam logic [ByteW-1:0] ChT      = 8'h54;  // 'T'
  localparam logic [ByteW-1:0] ChSlash  = 8'h2F;  // '/'
  localparam logic [ByteW-1:0] ChF      = 8'h46;  // 'F'
  localparam logic [ByteW-1:0] ChLo     = 8'h6F;  // 'o'
  localparam logic [ByteW-1:0] ChM      = 8'h4D;  // 'M'
  localparam logic [ByteW-1:0] ChC      = 8'h43;  // 'C'
  localparam logic [ByteW-1:0] ChLParen = 8'h28;  // '('
  localparam logic [ByteW-1:0] ChRParen = 8'h29;  // ')'
  localparam logic [ByteW-1:0] ChBslash = 8'h5C;  // backslash
  localparam logic [ByteW-1:0] ChFirst  = 8'h21;  // '!'
  localparam logic [ByteW-1:0] ChLast   = 8'h7E;  // '~'
  localparam logic [ByteW-1:0] ChSpace  = 8'h20;
  localparam logic [ByteW-1:0] ChCr     = 8'h0D;
  localparam logic [ByteW-1:0] ChLf     = 8'h0A;

  typedef logic [ByteW-1:0] byte_t;

  // Whitespace that may frame a two-letter operator.
  function automatic logic is_frame(input byte_t b);
    return (b == ChSpace) || (b == ChCr) || (b == ChLf);
  endfunction

endpackage

/* rtl/pdf_content_text_extractor.sv */
// Top level of the PDF content text extractor: token tracking and character output.
`timescale 1ns / 1ps

//  channel  | valid      | stall      | payload
//  ---------+------------+------------+----------------------------
//  in       | byte_valid | byte_stall | stream_byte, end_of_stream
//  out      | char_valid | char_stall | text_char
//
//  One byte per cycle is taken while byte_stall is low; a byte waits in the
//  input register, and the flag and history update and its character both
//  land at the edge on which it leaves, the character in the result register.
//  Reset clears all flags, the history and both pipeline valids.
//  A stall on the output holds the result register; the input stage then
//  stalls only when it holds a byte that would emit a character.

module pdf_content_text_extractor (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        byte_valid,
  output logic                        byte_stall,
  input  pdfte_pkg::byte_t            stream_byte,
  input  logic                        end_of_stream,
  output logic                        char_valid,
  input  logic                        char_stall,
  output logic [pdfte_pkg::CharW-1:0] text_char
);
  import pdfte_pkg::*;

  // Input register.
  logic  s1_valid;
  byte_t s1_byte;
  logic  s1_eos;

  // Parser state.
  logic  in_text_object, in_text_object_next;
  logic  in_string, in_string_next;
  logic  escape_pending, escape_pending_next;
  logic  footer_active, footer_active_next;
  byte_t hist [HistDepth];

  logic emit;
  logic out_free;
  logic s1_advance;
  logic saw_et, saw_bt, saw_fo, saw_emc;

  assign saw_et = (hist[1] == ChE) && (hist[2] == ChT) && is_frame(hist[0])
                  && is_frame(hist[3]);
  assign saw_bt = (hist[1] == ChB) && (hist[2] == ChT) && is_frame(hist[0])
                  && is_frame(hist[3]);
  assign saw_fo = ((hist[0] == ChSlash) && (hist[1] == ChF) && (hist[2] == ChLo))
               || ((hist[1] == ChSlash) && (hist[2] == ChF) && (hist[3] == ChLo));
  assign saw_emc = ((hist[0] == ChE) && (hist[1] == ChM) && (hist[2] == ChC))
                || ((hist[1] == ChE) && (hist[2] == ChM) && (hist[3] == ChC));

  always_comb begin
    in_text_object_next = in_text_object;
    in_string_next      = in_string;
    escape_pending_next = escape_pending;
    footer_active_next  = footer_active;
    emit                = 1'b0;
    if (in_text_object) begin
      if (!in_string && saw_et) begin
        in_text_object_next = 1'b0;
      end else if (s1_byte == ChLParen && !(in_string && escape_pending)) begin
        in_string_next = 1'b1;
      end else if (s1_byte == ChRParen && in_string && !escape_pending) begin
        in_string_next = 1'b0;
      end else if (in_string) begin
        if (s1_byte == ChBslash && !escape_pending) begin
          escape_pending_next = 1'b1;
        end else begin
          escape_pending_next = 1'b0;
          emit = (s1_byte >= ChFirst) && (s1_byte <= ChLast);
        end
      end
    end else if (!footer_active) begin
      if (saw_bt) begin
        in_text_object_next = 1'b1;
      end else if (saw_fo) begin
        footer_active_next = 1'b1;
      end
    end else if (saw_emc) begin
      footer_active_next = 1'b0;
    end
  end

  assign out_free   = !char_valid || !char_stall;
  assign s1_advance = s1_valid && (out_free || !emit);
  assign byte_stall = s1_valid && !s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!byte_stall) begin
      s1_valid <= byte_valid;
    end
    if (byte_valid && !byte_stall) begin
      s1_byte <= stream_byte;
      s1_eos  <= end_of_stream;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (s1_advance && s1_eos)) begin
      in_text_object <= 1'b0;
      in_string      <= 1'b0;
      escape_pending <= 1'b0;
      footer_active  <= 1'b0;
      for (int i = 0; i < HistDepth; i++) begin
        hist[i] <= '0;
      end
    end else if (s1_advance) begin
      in_text_object <= in_text_object_next;
      in_string      <= in_string_next;
      escape_pending <= escape_pending_next;
      footer_active  <= footer_active_next;
      for (int i = 0; i < HistDepth - 1; i++) begin
        hist[i] <= hist[i+1];
      end
      hist[HistDepth-1] <= s1_byte;
    end
  end

  // Result register; it loads whenever it is empty or its result is being taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (out_free) begin
      char_valid <= s1_advance && emit;
    end
    if (out_free && s1_advance && emit) begin
      text_char <= s1_byte[CharW-1:0];
    end
  end

`ifndef SYNTHESIS
  a_string_in_text: assert property (@(posedge clk) disable iff (rst)
    in_string |-> in_text_object)
    else $error("string flag set outside a text object");

  a_escape_in_string: assert property (@(posedge clk) disable iff (rst)
    escape_pending |-> in_string)
    else $error("escape pending outside a string");

  a_text_footer_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_text_object && footer_active))
    else $error("text object and footer both active");

  a_char_printable: assert property (@(posedge clk) disable iff (rst)
    char_valid |-> (text_char >= ChFirst[CharW-1:0]) && (text_char <= ChLast[CharW-1:0]))
    else $error("non-printable character presented");

  a_eos_clears: assert property (@(posedge clk) disable iff (rst)
    (s1_advance && s1_eos) |=> !in_text_object && !footer_active && !in_string
      && (hist[0] == 8'h00) && (hist[1] == 8'h00) && (hist[2] == 8'h00)
      && (hist[3] == 8'h00))
    else $error("state not cleared after end of stream");
`endif

endmodule
